// ===== hdl/fan_pwm_threshold_calibrator_macros.svh =====
// Assertion macros shared by the fan calibrator RTL.
// Depends on nothing; each macro expects aclk and aresetn in scope.
`ifndef FAN_PWM_THRESHOLD_CALIBRATOR_MACROS_SVH
`define FAN_PWM_THRESHOLD_CALIBRATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define FPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fpc_pkg.sv =====
// Package for the fan PWM threshold calibrator: codes, widths and the coarse step.
// Depends on nothing; imported by the top level.
`timescale 1ns / 1ps

package fpc_pkg;

    localparam int DUTY_W  = 8;
    localparam int RPM_W   = 16;
    localparam int COUNT_W = 4;
    localparam int FUNC_W  = 2;
    localparam int OUT_W   = 40;

    localparam logic [DUTY_W-1:0] DUTY_FULL   = 8'd255;
    localparam logic [DUTY_W-1:0] STOP_MARGIN = 8'd5;

    // Configuration register indexes.
    localparam logic REG_ZERO_LIMIT = 1'b0;
    localparam logic REG_INIT_MIN   = 1'b1;

    // Command codes carried on the input selector.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_ABORT = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    // Sequencer phase, also reported as status.
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_STOP   = 3'd1,
        PH_START  = 3'd2,
        PH_FINE   = 3'd3,
        PH_DONE   = 3'd4,
        PH_CANCEL = 3'd5,
        PH_ERROR  = 3'd6
    } phase_t;

    // Wait class for the next measurement.
    typedef enum logic [1:0] {
        WAIT_NONE  = 2'd0,
        WAIT_SHORT = 2'd1,
        WAIT_LONG  = 2'd2
    } wait_t;

    // Coarse step down: min(floor(19p/20), p-5), floored at zero.
    // floor(19p/20) = p - ceil(p/20), and ceil(p/20) = floor((p+19)/20),
    // taken as a reciprocal multiply that is exact for p+19 below 275.
    function automatic logic [DUTY_W-1:0] coarse_step(input logic [DUTY_W-1:0] p);
        logic [8:0]        biased;
        logic [20:0]       prod;
        logic [3:0]        ceil20;
        logic [3:0]        dec;
        begin
            biased = {1'b0, p} + 9'd19;
            prod   = 21'(biased) * 21'd3277;
            ceil20 = prod[19:16];
            dec    = (ceil20 > 4'd5) ? ceil20 : 4'd5;
            if (p < STOP_MARGIN) begin
                coarse_step = '0;
            end else begin
                coarse_step = p - {4'd0, dec};
            end
        end
    endfunction

endpackage

// ===== hdl/fan_pwm_threshold_calibrator.sv =====
// Top level of the fan PWM threshold calibrator: input register, sequencer, result register.
// Depends on fpc_pkg and fan_pwm_threshold_calibrator_macros.svh.
`timescale 1ns / 1ps

// Fan self-calibration sequencer. Each accepted item (start, abort, no command
// or a measurement tick with the tachometer rpm) yields exactly one result item:
// the item is held in the input register while the step logic works out the
// result, which is loaded into the result register once that register is free or
// being drained. A new item may be accepted in every cycle; throughput is one
// item per clock, limited only by back-pressure on the result channel. Registers
// must be written through the cfg port only while idle, which the block itself
// does not enforce; they take effect for the next item.

`include "fan_pwm_threshold_calibrator_macros.svh"

module fan_pwm_threshold_calibrator
    import fpc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // Configuration write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data,
    // Input items
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [RPM_W-1:0]  s_tdata,   // [15:0] rpm
    input  logic [FUNC_W-1:0] s_tuser,   // [1:0] func
    // Result items
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata    // [7:0] duty, [8] manual_mode, [11:9] status,
                                         // [19:12] start_duty, [27:20] stop_duty,
                                         // [35:28] min_duty, [36] never_stops,
                                         // [38:37] next_wait, [39] zero
);

    // Configuration registers
    logic [COUNT_W-1:0] zero_limit_reg;
    logic [DUTY_W-1:0]  init_min_reg;

    // Input register
    logic               in_valid_reg;
    logic [FUNC_W-1:0]  in_func_reg;
    logic [RPM_W-1:0]   in_rpm_reg;

    // Sequencer state
    phase_t             phase_reg,  phase_next;
    logic [DUTY_W-1:0]  duty_reg,   duty_next;
    logic [COUNT_W-1:0] zcount_reg, zcount_next;
    logic [DUTY_W-1:0]  start_reg,  start_next;
    logic [DUTY_W-1:0]  stop_reg,   stop_next;
    logic [DUTY_W-1:0]  min_reg,    min_next;
    logic               manual_reg, manual_next;
    logic               never_next;
    wait_t              wait_next;

    // Result register
    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;

    logic               advance;
    logic [DUTY_W-1:0]  duty_cand;
    logic               duty_write;
    logic [DUTY_W:0]    duty_plus2;
    logic [DUTY_W:0]    duty_plus5;

    // The step moves on when the result register is free or being drained.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign duty_plus2 = {1'b0, duty_reg} + 9'd2;
    assign duty_plus5 = {1'b0, duty_reg} + {1'b0, STOP_MARGIN};

    // Sequencer step for the item held in the input register.
    always_comb begin
        phase_next  = phase_reg;
        zcount_next = zcount_reg;
        start_next  = start_reg;
        stop_next   = stop_reg;
        min_next    = min_reg;
        never_next  = 1'b0;
        wait_next   = WAIT_NONE;
        duty_cand   = duty_reg;
        duty_write  = 1'b0;
        manual_next = manual_reg;

        case (func_t'(in_func_reg))
            FUNC_START: begin
                min_next   = init_min_reg;
                duty_cand  = DUTY_FULL;
                duty_write = 1'b1;
                phase_next = PH_STOP;
                wait_next  = WAIT_SHORT;
            end
            FUNC_ABORT: begin
                if (phase_reg == PH_STOP || phase_reg == PH_START || phase_reg == PH_FINE) begin
                    phase_next = PH_CANCEL;
                    duty_cand  = DUTY_FULL;
                    duty_write = 1'b1;
                end
            end
            FUNC_TICK: begin
                case (phase_reg)
                    PH_STOP: begin
                        if (in_rpm_reg != '0) begin
                            if (duty_reg == '0) begin
                                start_next = '0;
                                stop_next  = '0;
                                min_next   = '0;
                                duty_cand  = DUTY_FULL;
                                duty_write = 1'b1;
                                phase_next = PH_DONE;
                                never_next = 1'b1;
                            end else begin
                                duty_cand   = coarse_step(duty_reg);
                                duty_write  = 1'b1;
                                zcount_next = '0;
                                wait_next   = WAIT_SHORT;
                            end
                        end else begin
                            if (zcount_reg < zero_limit_reg) begin
                                zcount_next = zcount_reg + 4'd1;
                            end else begin
                                phase_next  = PH_START;
                                zcount_next = '0;
                            end
                            wait_next = WAIT_SHORT;
                        end
                    end
                    PH_START: begin
                        if (in_rpm_reg == '0) begin
                            if (duty_reg == DUTY_FULL) begin
                                phase_next  = PH_DONE;
                                zcount_next = '0;
                                stop_next   = DUTY_FULL;
                                start_next  = DUTY_FULL;
                            end else begin
                                duty_cand  = duty_plus2[DUTY_W] ? DUTY_FULL
                                                                : duty_plus2[DUTY_W-1:0];
                                duty_write = 1'b1;
                                wait_next  = WAIT_LONG;
                            end
                        end else begin
                            phase_next = PH_FINE;
                            start_next = duty_reg;
                            wait_next  = WAIT_LONG;
                        end
                    end
                    PH_FINE: begin
                        if (in_rpm_reg != '0) begin
                            duty_cand   = (duty_reg == '0) ? '0 : duty_reg - 8'd1;
                            duty_write  = 1'b1;
                            zcount_next = '0;
                            wait_next   = WAIT_LONG;
                        end else if (zcount_reg < zero_limit_reg) begin
                            zcount_next = zcount_reg + 4'd1;
                            wait_next   = WAIT_SHORT;
                        end else begin
                            phase_next  = PH_DONE;
                            zcount_next = '0;
                            stop_next   = duty_plus5[DUTY_W] ? DUTY_FULL
                                                             : duty_plus5[DUTY_W-1:0];
                            if (stop_next < min_reg) begin
                                min_next = stop_next;
                            end
                            duty_cand  = DUTY_FULL;
                            duty_write = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        // A duty change hands control to manual mode; abort returns it to full speed.
        duty_next = duty_cand;
        if (duty_write && duty_cand != duty_reg) begin
            manual_next = 1'b1;
        end
        if (phase_next == PH_CANCEL && phase_reg != PH_CANCEL) begin
            manual_next = 1'b0;
        end
    end

    // Registers: configuration, input stage, sequencer state and result stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_limit_reg <= 4'd10;
            init_min_reg   <= DUTY_FULL;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= PH_IDLE;
            duty_reg       <= '0;
            zcount_reg     <= '0;
            start_reg      <= DUTY_FULL;
            stop_reg       <= DUTY_FULL;
            min_reg        <= DUTY_FULL;
            manual_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_ZERO_LIMIT) begin
                    zero_limit_reg <= cfg_data[COUNT_W-1:0];
                end else begin
                    init_min_reg <= cfg_data;
                end
            end

            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (s_tvalid && s_tready) begin
                in_func_reg <= s_tuser;
                in_rpm_reg  <= s_tdata;
            end

            if (advance) begin
                phase_reg     <= phase_next;
                duty_reg      <= duty_next;
                zcount_reg    <= zcount_next;
                start_reg     <= start_next;
                stop_reg      <= stop_next;
                min_reg       <= min_next;
                manual_reg    <= manual_next;
                out_valid_reg <= 1'b1;
                out_data_reg  <= {1'b0, wait_next, never_next, min_next, stop_next,
                                  start_next, phase_next, manual_next, duty_next};
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // A result of the never-stops tick finishes the test and asks for no further tick.
    `FPC_ASSERT_NOW(a_never_done, m_tvalid && m_tdata[36],
                    m_tdata[11:9] == PH_DONE && m_tdata[38:37] == WAIT_NONE,
                    "never_stops result without finished status")

    // A long wait is only asked for during the start or fine search.
    `FPC_ASSERT_NOW(a_long_wait, m_tvalid && m_tdata[38:37] == WAIT_LONG,
                    m_tdata[11:9] == PH_START || m_tdata[11:9] == PH_FINE,
                    "long wait outside start or fine search")

    // A cancelled sequencer always reports full speed mode.
    `FPC_ASSERT_NOW(a_cancel_auto, m_tvalid && m_tdata[11:9] == PH_CANCEL,
                    !m_tdata[8] && m_tdata[7:0] == DUTY_FULL,
                    "cancelled result not at full speed")

    // State only moves when an item is stepped.
    `FPC_ASSERT_NEXT(a_state_hold, !advance,
                     $stable(phase_reg) && $stable(duty_reg) && $stable(zcount_reg),
                     "sequencer state changed without an item")

    // A new result appears only after an item sat in the input register.
    `FPC_ASSERT_NEXT(a_result_src, !out_valid_reg && !in_valid_reg, !out_valid_reg,
                     "result produced without an item")

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the fan PWM threshold calibrator.
// Depends on fpc_pkg and the calibrator RTL; every result item is predicted and checked on arrival.
`timescale 1ns / 1ps

module testbench
    import fpc_pkg::*;
();

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 1700;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 6;
    localparam int MAX_REPORTS   = 40;

    // Calibrator state as the predictor tracks it.
    typedef struct packed {
        phase_t     phase;
        logic [7:0] duty;
        logic [3:0] zeros;
        logic [7:0] start_found;
        logic [7:0] stop_found;
        logic [7:0] min_found;
        logic       manual;
    } cal_state_t;

    // One result item, field by field.
    typedef struct packed {
        logic [7:0] duty;
        logic       manual_mode;
        phase_t     status;
        logic [7:0] start_duty;
        logic [7:0] stop_duty;
        logic [7:0] min_duty;
        logic       never_stops;
        wait_t      next_wait;
    } cal_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = REG_ZERO_LIMIT;
    logic [7:0]  cfg_data  = 8'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = 16'd0;    // [15:0] rpm
    logic [1:0]  s_tuser   = FUNC_TICK; // [1:0] func
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;  // [7:0] duty, [8] manual_mode, [11:9] status, [19:12] start_duty,
                           // [27:20] stop_duty, [35:28] min_duty, [36] never_stops,
                           // [38:37] next_wait, [39] zero

    // Predictor state and its copy of the registers.
    cal_state_t  cal;
    logic [3:0]  zero_limit = 4'd10;
    logic [7:0]  init_min   = 8'd255;

    cal_result_t pending_results[$];
    int          errors      = 0;
    int          items_sent  = 0;
    int          cycle_count = 0;

    // Sender and receiver pacing.
    bit          tx_gaps      = 1'b1;
    int          burst_left   = 0;
    int          rx_hold_req  = 0;
    int          hold_left    = 0;
    int          rx_mode      = 0;
    int          rx_mode_left = 0;
    int          rx_phase_cnt = 0;

    fan_pwm_threshold_calibrator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #4 aclk = ~aclk;

    // Overall time limit.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Coarse step of the stop search, in plain integer arithmetic.
    function automatic logic [7:0] coarse_down(input logic [7:0] p);
        int v;
        int a;
        v = p;
        a = (v * 19) / 20;
        if (v < 5) return 8'd0;
        return 8'((v - 5) < a ? (v - 5) : a);
    endfunction

    // Any change of duty switches the fan to manual control.
    function automatic void set_duty(input logic [7:0] v);
        if (v != cal.duty) begin
            cal.duty   = v;
            cal.manual = 1'b1;
        end
    endfunction

    // Advances the calibrator by one input item and returns the result it gives.
    function automatic cal_result_t advance_calibrator(input func_t f, input logic [15:0] rpm);
        cal_result_t r;
        wait_t       nw;
        logic        never;
        int          d;
        nw    = WAIT_NONE;
        never = 1'b0;
        case (f)
            FUNC_START: begin
                cal.min_found = init_min;
                set_duty(DUTY_FULL);
                cal.phase = PH_STOP;
                nw = WAIT_SHORT;
            end
            FUNC_ABORT: begin
                if (cal.phase == PH_STOP || cal.phase == PH_START || cal.phase == PH_FINE) begin
                    cal.phase = PH_CANCEL;
                    set_duty(DUTY_FULL);
                    cal.manual = 1'b0;
                end
            end
            FUNC_TICK: begin
                case (cal.phase)
                    PH_STOP: begin
                        if (rpm != 16'd0) begin
                            if (cal.duty == 8'd0) begin
                                // The fan still spins with the PWM off.
                                cal.start_found = 8'd0;
                                cal.stop_found  = 8'd0;
                                cal.min_found   = 8'd0;
                                set_duty(DUTY_FULL);
                                cal.phase = PH_DONE;
                                never = 1'b1;
                            end else begin
                                set_duty(coarse_down(cal.duty));
                                cal.zeros = 4'd0;
                                nw = WAIT_SHORT;
                            end
                        end else begin
                            if (cal.zeros < zero_limit) begin
                                cal.zeros = cal.zeros + 4'd1;
                            end else begin
                                cal.phase = PH_START;
                                cal.zeros = 4'd0;
                            end
                            nw = WAIT_SHORT;
                        end
                    end
                    PH_START: begin
                        if (rpm == 16'd0) begin
                            if (cal.duty == DUTY_FULL) begin
                                // Never started, even at full duty.
                                cal.phase       = PH_DONE;
                                cal.zeros       = 4'd0;
                                cal.stop_found  = DUTY_FULL;
                                cal.start_found = DUTY_FULL;
                            end else begin
                                d = cal.duty + 2;
                                set_duty(d > 255 ? DUTY_FULL : 8'(d));
                                nw = WAIT_LONG;
                            end
                        end else begin
                            cal.phase       = PH_FINE;
                            cal.start_found = cal.duty;
                            nw = WAIT_LONG;
                        end
                    end
                    PH_FINE: begin
                        if (rpm != 16'd0) begin
                            set_duty(cal.duty == 8'd0 ? 8'd0 : cal.duty - 8'd1);
                            cal.zeros = 4'd0;
                            nw = WAIT_LONG;
                        end else if (cal.zeros < zero_limit) begin
                            cal.zeros = cal.zeros + 4'd1;
                            nw = WAIT_SHORT;
                        end else begin
                            cal.phase = PH_DONE;
                            cal.zeros = 4'd0;
                            d = cal.duty + STOP_MARGIN;
                            cal.stop_found = d > 255 ? DUTY_FULL : 8'(d);
                            if (cal.stop_found < cal.min_found) cal.min_found = cal.stop_found;
                            set_duty(DUTY_FULL);
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.duty        = cal.duty;
        r.manual_mode = cal.manual;
        r.status      = cal.phase;
        r.start_duty  = cal.start_found;
        r.stop_duty   = cal.stop_found;
        r.min_duty    = cal.min_found;
        r.never_stops = never;
        r.next_wait   = nw;
        return r;
    endfunction

    // Random tachometer readings: zero, full scale or anything.
    function automatic logic [15:0] any_rpm();
        case ($urandom_range(3))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic logic [15:0] spin_rpm();
        case ($urandom_range(5))
            0:       return 16'd1;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(16'hFFFF, 1));
        endcase
    endfunction

    task automatic check_field(input string name, input int expv, input int actv);
        if (expv != actv) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
        end
    endtask

    // Compare each result item with the oldest prediction.
    always @(posedge aclk) begin : result_check
        cal_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result item with none expected, expected nothing, actual %h",
                             $time, m_tdata);
            end else begin
                want = pending_results.pop_front();
                check_field("duty", want.duty, m_tdata[7:0]);
                check_field("manual_mode", want.manual_mode, m_tdata[8]);
                check_field("status", int'(want.status), m_tdata[11:9]);
                check_field("start_duty", want.start_duty, m_tdata[19:12]);
                check_field("stop_duty", want.stop_duty, m_tdata[27:20]);
                check_field("min_duty", want.min_duty, m_tdata[35:28]);
                check_field("never_stops", want.never_stops, m_tdata[36]);
                check_field("next_wait", int'(want.next_wait), m_tdata[38:37]);
                check_field("padding", 0, m_tdata[39]);
            end
        end
    end

    // Receiver: changes its stall pattern now and then, and honours a requested hold-off.
    always @(posedge aclk) begin : rx_stall
        logic rdy;
        if (rx_hold_req != 0) begin
            hold_left   = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(2);
            rx_mode_left = $urandom_range(200, 20);
        end
        rx_mode_left--;
        rx_phase_cnt++;
        if (hold_left != 0) begin
            rdy = 1'b0;
            hold_left--;
        end else begin
            case (rx_mode)
                0:       rdy = 1'b1;
                1:       rdy = ($urandom_range(99) >= 35);
                default: rdy = (rx_phase_cnt % 5) < 3;
            endcase
        end
        m_tready <= rdy;
    end

    // Offers one item and waits until it is taken; tvalid stays high for a following item.
    task automatic send_item(input func_t f, input logic [15:0] rpm);
        int gap;
        if (tx_gaps) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(6, 1);
                burst_left = $urandom_range(24, 1);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= rpm;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(advance_calibrator(f, rpm));
        items_sent++;
    endtask

    // Stops offering and waits until every predicted result has arrived.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes both registers back to back; only called while the block is idle.
    task automatic configure(input logic [3:0] limit, input logic [7:0] min_duty);
        cfg_valid <= 1'b1;
        cfg_index <= REG_ZERO_LIMIT;
        cfg_data  <= {4'd0, limit};
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        zero_limit = limit;
        cfg_index <= REG_INIT_MIN;
        cfg_data  <= min_duty;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        init_min = min_duty;
        cfg_valid <= 1'b0;
    endtask

    // Commands outside a search and a cancelled test, with the reset register values.
    task automatic test_idle_commands();
        send_item(FUNC_TICK, 16'd0);
        send_item(FUNC_TICK, 16'hFFFF);
        send_item(FUNC_ABORT, 16'h0000);
        send_item(FUNC_NONE, 16'hA5A5);
        send_item(FUNC_START, 16'h5A5A);
        send_item(FUNC_ABORT, 16'hFFFF);
        send_item(FUNC_ABORT, 16'd0);
        send_item(FUNC_TICK, 16'h5A5A);
        send_item(FUNC_NONE, 16'd0);
        drain_results();
    endtask

    // One full pass through the three phases, then a restart and an abort mid-search.
    task automatic test_search_phases();
        configure(4'd0, 8'd0);
        send_item(FUNC_START, 16'd0);
        send_item(FUNC_TICK, 16'd100);
        send_item(FUNC_TICK, 16'd0);
        send_item(FUNC_TICK, 16'd0);
        send_item(FUNC_TICK, 16'd0);
        send_item(FUNC_TICK, 16'd5);
        send_item(FUNC_TICK, 16'd1);
        send_item(FUNC_TICK, 16'd0);
        send_item(FUNC_START, 16'd0);
        send_item(FUNC_TICK, 16'd0);
        send_item(FUNC_START, 16'hFFFF);
        send_item(FUNC_ABORT, 16'd0);
        drain_results();
    endtask

    // Start search up to full duty: stop margin clipped, then a fan that never starts.
    task automatic test_duty_ceiling();
        configure(4'd0, 8'd255);
        send_item(FUNC_START, 16'd0);
        send_item(FUNC_TICK, 16'd7);
        send_item(FUNC_TICK, 16'd0);
        repeat (6) send_item(FUNC_TICK, 16'd0);
        send_item(FUNC_TICK, 16'd1);
        send_item(FUNC_TICK, 16'd0);
        send_item(FUNC_START, 16'd0);
        send_item(FUNC_TICK, 16'd9);
        send_item(FUNC_TICK, 16'd0);
        repeat (8) send_item(FUNC_TICK, 16'd0);
        drain_results();
    endtask

    // Coarse search down to duty zero: a fan that never stops, then a fine search held at zero.
    task automatic test_never_stops();
        configure(4'd1, 8'd200);
        send_item(FUNC_START, 16'd0);
        while (cal.phase == PH_STOP && cal.duty != 8'd0) send_item(FUNC_TICK, spin_rpm());
        send_item(FUNC_TICK, spin_rpm());
        send_item(FUNC_START, 16'd0);
        while (cal.phase == PH_STOP && cal.duty != 8'd0) send_item(FUNC_TICK, spin_rpm());
        while (cal.phase == PH_STOP) send_item(FUNC_TICK, 16'd0);
        send_item(FUNC_TICK, spin_rpm());
        send_item(FUNC_TICK, spin_rpm());
        while (cal.phase == PH_FINE) send_item(FUNC_TICK, 16'd0);
        drain_results();
    endtask

    // The receiver holds off for a long stretch while items keep coming.
    task automatic test_backpressure();
        configure(4'd15, 8'd77);
        tx_gaps     = 1'b0;
        rx_hold_req = HOLD_CYCLES;
        send_item(FUNC_START, 16'd0);
        repeat (63) begin
            if ($urandom_range(7) == 0)
                send_item(func_t'($urandom_range(3)), any_rpm());
            else
                send_item(FUNC_TICK, ($urandom_range(2) == 0) ? 16'd0 : spin_rpm());
        end
        drain_results();
        tx_gaps = 1'b1;
    endtask

    // One calibration run with random content, or a short burst of noise.
    task automatic run_sequence();
        int kind;
        int n;
        int guard;
        kind = $urandom_range(99);
        if (kind < 15) begin
            n = $urandom_range(8, 1);
            repeat (n) send_item(func_t'($urandom_range(3)), any_rpm());
        end else begin
            send_item(FUNC_START, any_rpm());
            // Coarse steps down, now and then all the way to zero.
            n = (kind < 25) ? 60 : $urandom_range(12);
            while (n > 0 && cal.phase == PH_STOP) begin
                send_item(FUNC_TICK, spin_rpm());
                n--;
            end
            if ($urandom_range(19) == 0) send_item(func_t'($urandom_range(2, 1)), any_rpm());
            // Stopped readings until the start search; a stray reading resets the count.
            guard = 100;
            while (cal.phase == PH_STOP && guard > 0) begin
                send_item(FUNC_TICK, ($urandom_range(24) == 0) ? spin_rpm() : 16'd0);
                guard--;
            end
            // Duty rises until the fan starts, sometimes up to full duty.
            n = $urandom_range(kind < 35 ? 140 : 10);
            while (cal.phase == PH_START && n > 0) begin
                send_item(FUNC_TICK, 16'd0);
                n--;
            end
            if ($urandom_range(19) == 0) send_item(func_t'($urandom_range(2, 1)), any_rpm());
            if (cal.phase == PH_START) send_item(FUNC_TICK, spin_rpm());
            // Fine steps down, then stopped readings until the end.
            n = $urandom_range(8);
            while (cal.phase == PH_FINE && n > 0) begin
                send_item(FUNC_TICK, spin_rpm());
                n--;
            end
            guard = 100;
            while (cal.phase == PH_FINE && guard > 0) begin
                send_item(FUNC_TICK, ($urandom_range(24) == 0) ? spin_rpm() : 16'd0);
                guard--;
            end
            if ($urandom_range(9) == 0) send_item(FUNC_ABORT, any_rpm());
        end
    endtask

    // Random runs across a series of register settings, extremes first.
    task automatic test_random_sequences();
        int target;
        int phase_end;
        int setting;
        target  = items_sent + RANDOM_ITEMS;
        setting = 0;
        while (items_sent < target) begin
            drain_results();
            case (setting)
                0:       configure(4'd15, 8'd255);
                1:       configure(4'd0, 8'd0);
                2:       configure(4'd15, 8'd0);
                3:       configure(4'd0, 8'd255);
                4:       configure(4'd10, 8'd255);
                default: configure(4'($urandom_range(15)), 8'($urandom_range(255)));
            endcase
            setting++;
            tx_gaps   = ($urandom_range(3) != 0);
            phase_end = items_sent + $urandom_range(180, 60);
            while (items_sent < phase_end && items_sent < target) run_sequence();
        end
        drain_results();
    endtask

    initial begin
        cal = '{phase: PH_IDLE, duty: 8'd0, zeros: 4'd0, start_found: 8'd255,
                stop_found: 8'd255, min_found: 8'd255, manual: 1'b0};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_idle_commands();
        test_search_phases();
        test_duty_ceiling();
        test_never_stops();
        test_backpressure();
        test_random_sequences();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/fpc_pkg.sv
hdl/fan_pwm_threshold_calibrator.sv
verif/testbench.sv
